// ===== rtl/assert_macros.svh =====
// Assertion macros for the RTL that checks its own behaviour.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define NCBF_ASSERT(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// When the antecedent holds, the consequent must hold at the next clock edge.
`define NCBF_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/ncbf_pkg.sv =====
// Package with the types, codes and sizes of the note-coded Brainfuck machine.
`default_nettype none

package ncbf_pkg;

  localparam int TAPE_CELLS    = 32768;
  localparam int CELL_MODULUS  = 256;
  localparam int PROGRAM_DEPTH = 4096;
  localparam int SLICE_STEPS   = 65536;

  localparam int DP_W   = $clog2(TAPE_CELLS);
  localparam int CELL_W = $clog2(CELL_MODULUS);
  localparam int PA_W   = $clog2(PROGRAM_DEPTH);
  localparam int PC_W   = PA_W + 1;
  localparam int STEP_W = $clog2(SLICE_STEPS);
  localparam int ALU_W  = (DP_W > PC_W) ? ((DP_W > CELL_W) ? DP_W : CELL_W)
                                        : ((PC_W > CELL_W) ? PC_W : CELL_W);

  localparam logic [7:0] SKIP_MASK = 8'h0A;
  localparam logic [3:0] ONE_MASK  = 4'hA;

  // Command opcodes.
  localparam logic [1:0] OPC_LOAD  = 2'd0;
  localparam logic [1:0] OPC_CLEAR = 2'd1;
  localparam logic [1:0] OPC_START = 2'd2;
  localparam logic [1:0] OPC_CONT  = 2'd3;

  // Result status codes.
  localparam logic [2:0] ST_ACK        = 3'd0;
  localparam logic [2:0] ST_OUTPUT     = 3'd1;
  localparam logic [2:0] ST_NEED_INPUT = 3'd2;
  localparam logic [2:0] ST_HALTED     = 3'd3;
  localparam logic [2:0] ST_BRACKET    = 3'd4;
  localparam logic [2:0] ST_FULL       = 3'd5;
  localparam logic [2:0] ST_NOT_PAUSED = 3'd6;

  // Instruction codes, in the order > < + - . , [ ].
  localparam logic [2:0] INS_RIGHT = 3'd0;
  localparam logic [2:0] INS_LEFT  = 3'd1;
  localparam logic [2:0] INS_INC   = 3'd2;
  localparam logic [2:0] INS_DEC   = 3'd3;
  localparam logic [2:0] INS_OUT   = 3'd4;
  localparam logic [2:0] INS_IN    = 3'd5;
  localparam logic [2:0] INS_OPEN  = 3'd6;
  localparam logic [2:0] INS_CLOSE = 3'd7;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] object_flags;
    logic [3:0] sound_flags;
    logic [7:0] input_byte;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  out_byte;
    logic [12:0] program_length;
  } result_t;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_RESUME,
    MODE_WAIT
  } mode_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_SKIP_IN,
    S_FETCH,
    S_EXEC,
    S_ADV,
    S_SF_INC,
    S_SF_CHK,
    S_SF_DEP,
    S_SB_CHK,
    S_SB_DEP
  } state_t;

  typedef enum logic {
    ALU_INC,
    ALU_DEC
  } alu_op_t;

  typedef struct packed {
    alu_op_t          op;
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] limit;
  } alu_req_t;

  typedef struct packed {
    logic [ALU_W-1:0] res;
    logic             a_zero;
    logic             res_zero;
  } alu_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/note_coded_brainfuck_machine.sv =====
// Top level of the note-coded Brainfuck machine: sequencer, stores and step unit.
`default_nettype none
`include "assert_macros.svh"

// A command word is taken at a rising edge where start is high and busy is
// low, and every command answers with exactly one result word, shown for a
// single cycle while done is high; the receiver cannot stall, so it must
// take the word in that cycle. Load, clear and a continue while nothing is
// paused answer in the cycle after acceptance. After reset, and on every
// start command, the whole tape is swept to zero, one cell a cycle, with
// busy high, before anything else happens. A run then passes each movement,
// arithmetic or untaken bracket instruction through fetch, execute and
// advance; an output or input instruction through fetch and execute, which
// ends the run; and the end of the program is found at a fetch. A forward
// bracket jump passes each instruction through increment, check and depth
// states, a backward one through check and depth states; a continue after
// an input request first passes the read instruction. The pace is set by
// the single step unit, which carries the pointer, cell and depth steps,
// and by the registered read of the program and tape memories. A run stops
// at an output, an input request, the end of the program, an unmatched
// bracket, or after SLICE_STEPS instructions without such an event, when it
// answers with an acknowledge and waits for a continue.
module note_coded_brainfuck_machine
  import ncbf_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    start,
  input  wire cmd_t    cmd,
  output logic         busy,
  output logic         done,
  output result_t      result
);

  state_t            state, state_next;
  mode_t             mode, mode_next;
  logic [PC_W-1:0]   prog_count, prog_count_next;
  logic [2:0]        partial, partial_next;
  logic [1:0]        bits, bits_next;
  logic [DP_W-1:0]   dp, dp_next;
  logic [PC_W-1:0]   pc, pc_next;
  logic [PC_W-1:0]   depth, depth_next;
  logic [PC_W-1:0]   scan_idx, scan_idx_next;
  logic [STEP_W-1:0] step, step_next;
  logic [DP_W-1:0]   clr_addr, clr_addr_next;
  logic              run_after_clear, run_after_clear_next;
  logic              done_next;
  result_t           result_next;

  logic              prog_we;
  logic [PA_W-1:0]   prog_waddr;
  logic [2:0]        prog_wdata;
  logic [PA_W-1:0]   prog_raddr;
  logic [2:0]        prog_rdata;

  logic              tape_we;
  logic [DP_W-1:0]   tape_waddr;
  logic [CELL_W-1:0] tape_wdata;
  logic [CELL_W-1:0] tape_rdata;

  alu_req_t          alu_req;
  alu_rsp_t          alu_rsp;

  ncbf_ram #(
    .DEPTH (PROGRAM_DEPTH),
    .WIDTH (3)
  ) u_prog_ram (
    .clk   (clk),
    .we    (prog_we),
    .waddr (prog_waddr),
    .wdata (prog_wdata),
    .raddr (prog_raddr),
    .rdata (prog_rdata)
  );

  // The tape is always read at the data pointer.
  ncbf_ram #(
    .DEPTH (TAPE_CELLS),
    .WIDTH (CELL_W)
  ) u_tape_ram (
    .clk   (clk),
    .we    (tape_we),
    .waddr (tape_waddr),
    .wdata (tape_wdata),
    .raddr (dp),
    .rdata (tape_rdata)
  );

  ncbf_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_CLEAR;
      mode            <= MODE_IDLE;
      prog_count      <= '0;
      partial         <= '0;
      bits            <= '0;
      dp              <= '0;
      pc              <= '0;
      depth           <= '0;
      scan_idx        <= '0;
      step            <= '0;
      clr_addr        <= '0;
      run_after_clear <= 1'b0;
      done            <= 1'b0;
    end else begin
      state           <= state_next;
      mode            <= mode_next;
      prog_count      <= prog_count_next;
      partial         <= partial_next;
      bits            <= bits_next;
      dp              <= dp_next;
      pc              <= pc_next;
      depth           <= depth_next;
      scan_idx        <= scan_idx_next;
      step            <= step_next;
      clr_addr        <= clr_addr_next;
      run_after_clear <= run_after_clear_next;
      done            <= done_next;
    end
  end

  // The result word is payload and needs no reset.
  always_ff @(posedge clk) begin
    result <= result_next;
  end

  always_comb begin
    logic       fin;
    logic [2:0] fin_status;
    logic [7:0] fin_byte;
    logic [2:0] tok;
    logic       tok_bit;

    fin        = 1'b0;
    fin_status = ST_ACK;
    fin_byte   = '0;
    tok        = '0;
    tok_bit    = 1'b0;

    state_next           = state;
    mode_next            = mode;
    prog_count_next      = prog_count;
    partial_next         = partial;
    bits_next            = bits;
    dp_next              = dp;
    pc_next              = pc;
    depth_next           = depth;
    scan_idx_next        = scan_idx;
    step_next            = step;
    clr_addr_next        = clr_addr;
    run_after_clear_next = run_after_clear;
    done_next            = 1'b0;
    result_next          = result;

    prog_we    = 1'b0;
    prog_waddr = prog_count[PA_W-1:0];
    prog_wdata = '0;
    prog_raddr = pc[PA_W-1:0];

    tape_we    = 1'b0;
    tape_waddr = dp;
    tape_wdata = CELL_W'(alu_rsp.res);

    // By default the step unit advances the program counter without wrap.
    alu_req.op    = ALU_INC;
    alu_req.a     = ALU_W'(pc);
    alu_req.limit = '1;

    case (state)
      S_CLEAR: begin
        tape_we       = 1'b1;
        tape_waddr    = clr_addr;
        tape_wdata    = '0;
        clr_addr_next = clr_addr + DP_W'(1);
        if (clr_addr == DP_W'(TAPE_CELLS - 1)) begin
          clr_addr_next        = '0;
          run_after_clear_next = 1'b0;
          state_next           = run_after_clear ? S_FETCH : S_IDLE;
        end
      end

      S_IDLE: begin
        if (start) begin
          case (cmd.opcode)
            OPC_LOAD: begin
              fin = 1'b1;
              if ((cmd.object_flags & SKIP_MASK) == 8'd0) begin
                tok_bit = ((cmd.sound_flags & ONE_MASK) != 4'd0);
                tok     = partial | (tok_bit ? (3'b100 >> bits) : 3'b000);
                if (bits == 2'd2) begin
                  if (prog_count < PC_W'(PROGRAM_DEPTH)) begin
                    prog_we         = 1'b1;
                    prog_wdata      = tok;
                    prog_count_next = prog_count + PC_W'(1);
                  end else begin
                    fin_status = ST_FULL;
                  end
                  partial_next = '0;
                  bits_next    = '0;
                end else begin
                  partial_next = tok;
                  bits_next    = bits + 2'd1;
                end
              end
            end
            OPC_CLEAR: begin
              fin             = 1'b1;
              prog_count_next = '0;
              partial_next    = '0;
              bits_next       = '0;
              mode_next       = MODE_IDLE;
            end
            OPC_START: begin
              dp_next              = '0;
              pc_next              = '0;
              depth_next           = '0;
              step_next            = '0;
              run_after_clear_next = 1'b1;
              state_next           = S_CLEAR;
            end
            default: begin
              step_next = '0;
              case (mode)
                MODE_WAIT: begin
                  // The pending read instruction takes the byte, then is passed.
                  tape_we    = 1'b1;
                  tape_wdata = CELL_W'(cmd.input_byte);
                  state_next = S_SKIP_IN;
                end
                MODE_RESUME: begin
                  state_next = S_FETCH;
                end
                default: begin
                  fin        = 1'b1;
                  fin_status = ST_NOT_PAUSED;
                end
              endcase
            end
          endcase
        end
      end

      S_SKIP_IN: begin
        pc_next    = PC_W'(alu_rsp.res);
        state_next = S_FETCH;
      end

      S_FETCH: begin
        if (pc >= prog_count) begin
          mode_next  = MODE_IDLE;
          fin        = 1'b1;
          fin_status = ST_HALTED;
        end else begin
          state_next = S_EXEC;
        end
      end

      S_EXEC: begin
        state_next = S_ADV;
        case (prog_rdata)
          INS_RIGHT, INS_LEFT: begin
            alu_req.op    = (prog_rdata == INS_RIGHT) ? ALU_INC : ALU_DEC;
            alu_req.a     = ALU_W'(dp);
            alu_req.limit = ALU_W'(TAPE_CELLS - 1);
            dp_next       = DP_W'(alu_rsp.res);
          end
          INS_INC, INS_DEC: begin
            alu_req.op    = (prog_rdata == INS_INC) ? ALU_INC : ALU_DEC;
            alu_req.a     = ALU_W'(tape_rdata);
            alu_req.limit = ALU_W'(CELL_MODULUS - 1);
            tape_we       = 1'b1;
          end
          INS_OUT: begin
            pc_next    = PC_W'(alu_rsp.res);
            mode_next  = MODE_RESUME;
            fin        = 1'b1;
            fin_status = ST_OUTPUT;
            fin_byte   = 8'(tape_rdata);
          end
          INS_IN: begin
            mode_next  = MODE_WAIT;
            fin        = 1'b1;
            fin_status = ST_NEED_INPUT;
          end
          INS_OPEN: begin
            if (tape_rdata == '0) begin
              depth_next    = PC_W'(1);
              scan_idx_next = pc;
              state_next    = S_SF_INC;
            end
          end
          default: begin
            if (tape_rdata != '0) begin
              depth_next    = PC_W'(1);
              scan_idx_next = pc;
              state_next    = S_SB_CHK;
            end
          end
        endcase
      end

      S_ADV: begin
        pc_next = PC_W'(alu_rsp.res);
        if (step == STEP_W'(SLICE_STEPS - 1)) begin
          mode_next = MODE_RESUME;
          fin       = 1'b1;
        end else begin
          step_next  = step + STEP_W'(1);
          state_next = S_FETCH;
        end
      end

      S_SF_INC: begin
        alu_req.a     = ALU_W'(scan_idx);
        scan_idx_next = PC_W'(alu_rsp.res);
        state_next    = S_SF_CHK;
      end

      S_SF_CHK: begin
        prog_raddr = scan_idx[PA_W-1:0];
        if (scan_idx >= prog_count) begin
          mode_next  = MODE_IDLE;
          depth_next = '0;
          fin        = 1'b1;
          fin_status = ST_BRACKET;
        end else begin
          state_next = S_SF_DEP;
        end
      end

      S_SF_DEP: begin
        alu_req.a  = ALU_W'(depth);
        state_next = S_SF_INC;
        if (prog_rdata == INS_OPEN) begin
          depth_next = PC_W'(alu_rsp.res);
        end else if (prog_rdata == INS_CLOSE) begin
          alu_req.op = ALU_DEC;
          depth_next = PC_W'(alu_rsp.res);
          if (alu_rsp.res_zero) begin
            pc_next    = scan_idx;
            state_next = S_ADV;
          end
        end
      end

      S_SB_CHK: begin
        alu_req.op = ALU_DEC;
        alu_req.a  = ALU_W'(scan_idx);
        prog_raddr = PA_W'(alu_rsp.res);
        if (alu_rsp.a_zero) begin
          mode_next  = MODE_IDLE;
          depth_next = '0;
          fin        = 1'b1;
          fin_status = ST_BRACKET;
        end else begin
          scan_idx_next = PC_W'(alu_rsp.res);
          state_next    = S_SB_DEP;
        end
      end

      S_SB_DEP: begin
        alu_req.a  = ALU_W'(depth);
        state_next = S_SB_CHK;
        if (prog_rdata == INS_CLOSE) begin
          depth_next = PC_W'(alu_rsp.res);
        end else if (prog_rdata == INS_OPEN) begin
          alu_req.op = ALU_DEC;
          depth_next = PC_W'(alu_rsp.res);
          if (alu_rsp.res_zero) begin
            pc_next    = scan_idx;
            state_next = S_ADV;
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    // Every command ends with one result word and a return to idle.
    if (fin) begin
      done_next                  = 1'b1;
      result_next.status         = fin_status;
      result_next.out_byte       = fin_byte;
      result_next.program_length = 13'(prog_count_next);
      state_next                 = S_IDLE;
    end
  end

  // A result is only ever shown once the sequencer is back at idle.
  `NCBF_ASSERT(a_done_idle, !done || !busy, "result shown while the machine is busy")

  // An accepted command either starts work or answers in the next cycle.
  `NCBF_ASSERT_NEXT(a_cmd_progress, start && !busy, busy || done, "command accepted but lost")

  // Only an output instruction carries a byte.
  `NCBF_ASSERT(a_byte_only_output, !done || result.status == ST_OUTPUT || result.out_byte == 8'd0,
               "byte reported without an output instruction")

  // The reported program length never exceeds the store.
  `NCBF_ASSERT(a_length_bound, !done || result.program_length <= 13'(PROGRAM_DEPTH),
               "program length beyond store depth")

endmodule

`default_nettype wire

// ===== rtl/ncbf_ram.sv =====
// Simple dual-port RAM with one write port and one registered read port.
`default_nettype none

module ncbf_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/ncbf_alu.sv =====
// Shared step unit: increments or decrements one operand with wrap at a limit.
`default_nettype none

module ncbf_alu
  import ncbf_pkg::*;
(
  input  wire alu_req_t req,
  output alu_rsp_t      rsp
);

  logic [ALU_W-1:0] res;

  always_comb begin
    case (req.op)
      ALU_INC: res = (req.a == req.limit) ? '0 : req.a + ALU_W'(1);
      ALU_DEC: res = (req.a == '0) ? req.limit : req.a - ALU_W'(1);
      default: res = req.a;
    endcase
  end

  assign rsp.res      = res;
  assign rsp.a_zero   = (req.a == '0);
  assign rsp.res_zero = (res == '0);

endmodule

`default_nettype wire

// ===== tb/tb_note_coded_brainfuck_machine.sv =====
// Self-checking testbench that loads note-coded programs into the Brainfuck machine and runs them.
`timescale 1ns / 1ps

module tb_note_coded_brainfuck_machine;
  import ncbf_pkg::*;

  // Most of the simulated time goes to the tape sweep on each start, one run that overruns
  // a time slice, and the longest random loops. The limit leaves room for the slowest
  // random programs several times over.
  localparam int          CYCLE_LIMIT  = 50000000;
  localparam int unsigned GAP_MAX      = 13;
  localparam int unsigned RANDOM_WORDS = 800;
  localparam int          TAIL_CYCLES  = 40;

  logic    clk   = 1'b0;
  logic    rst   = 1'b1;
  logic    start = 1'b0;
  cmd_t    cmd   = '0;
  logic    busy;
  logic    done;
  result_t result;

  note_coded_brainfuck_machine u_top (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

  always #2 clk = ~clk;

  // Shadow copy of the machine. It is updated once for every command word the block
  // accepts, in the order the words were accepted.
  logic [2:0]        prog_mem [PROGRAM_DEPTH];
  int unsigned       prog_len   = 0;
  logic [2:0]        token_acc  = '0;
  int unsigned       token_bits = 0;
  logic [CELL_W-1:0] tape_mem [TAPE_CELLS];
  logic [DP_W-1:0]   head       = '0;
  int unsigned       pc         = 0;
  mode_t             mode       = MODE_IDLE;

  // Results still owed by the block, oldest first.
  result_t     answers_due[$];
  result_t     want_word;
  int unsigned words_sent    = 0;
  int unsigned results_seen  = 0;
  int unsigned bytes_out     = 0;
  int unsigned input_waits   = 0;
  int unsigned programs_run  = 0;
  int unsigned errors        = 0;
  int          cycles        = 0;

  // When set, words go back to back with no idle cycles. Otherwise each word waits a
  // random number of cycles. skip_pct is the chance, in percent, of a skipped note
  // being slipped in ahead of each real note.
  bit          pace_free = 1'b0;
  int unsigned skip_pct  = 0;

  // Execute the program from the current position. The run stops at an output, an input
  // request, the end of the program, an unmatched bracket, or the end of a time slice.
  function automatic void bf_run(output logic [2:0] st, output logic [7:0] ob);
    int unsigned       steps;
    int unsigned       i;
    int unsigned       depth;
    logic [CELL_W-1:0] cur;
    st = ST_ACK;
    ob = '0;
    for (steps = 0; steps < SLICE_STEPS; steps++) begin
      if (pc >= prog_len) begin
        mode = MODE_IDLE;
        st = ST_HALTED;
        return;
      end
      cur = tape_mem[head];
      case (prog_mem[pc])
        INS_RIGHT: head = head + 1'b1;
        INS_LEFT:  head = head - 1'b1;
        INS_INC:   tape_mem[head] = cur + 1'b1;
        INS_DEC:   tape_mem[head] = cur - 1'b1;
        INS_OUT: begin
          ob = cur;
          pc++;
          mode = MODE_RESUME;
          st = ST_OUTPUT;
          return;
        end
        INS_IN: begin
          // The read is finished by the continue that brings the byte in.
          mode = MODE_WAIT;
          st = ST_NEED_INPUT;
          return;
        end
        INS_OPEN: if (cur == 0) begin
          depth = 1;
          i = pc;
          while (depth != 0) begin
            i++;
            if (i >= prog_len) begin
              mode = MODE_IDLE;
              st = ST_BRACKET;
              return;
            end
            if (prog_mem[i] == INS_OPEN) depth++;
            else if (prog_mem[i] == INS_CLOSE) depth--;
          end
          pc = i;
        end
        default: if (cur != 0) begin
          depth = 1;
          i = pc;
          while (depth != 0) begin
            if (i == 0) begin
              mode = MODE_IDLE;
              st = ST_BRACKET;
              return;
            end
            i--;
            if (prog_mem[i] == INS_CLOSE) depth++;
            else if (prog_mem[i] == INS_OPEN) depth--;
          end
          pc = i;
        end
      endcase
      pc++;
    end
    // The time slice is used up. The run can be resumed with a continue.
    mode = MODE_RESUME;
    st = ST_ACK;
  endfunction

  // Apply one accepted command word to the shadow machine and return its answer.
  function automatic result_t bf_answer(cmd_t c);
    result_t    r;
    logic [2:0] st;
    logic [7:0] ob;
    st = ST_ACK;
    ob = '0;
    case (c.opcode)
      OPC_LOAD: if ((c.object_flags & SKIP_MASK) == 0) begin
        if ((c.sound_flags & ONE_MASK) != 0) token_acc[2 - token_bits] = 1'b1;
        token_bits++;
        if (token_bits == 3) begin
          if (prog_len < PROGRAM_DEPTH) begin
            prog_mem[prog_len] = token_acc;
            prog_len++;
          end else begin
            st = ST_FULL;
          end
          token_acc = '0;
          token_bits = 0;
        end
      end
      OPC_CLEAR: begin
        prog_len = 0;
        token_acc = '0;
        token_bits = 0;
        mode = MODE_IDLE;
      end
      OPC_START: begin
        foreach (tape_mem[k]) tape_mem[k] = '0;
        head = '0;
        pc = 0;
        bf_run(st, ob);
      end
      default: if (mode == MODE_IDLE) begin
        st = ST_NOT_PAUSED;
      end else begin
        if (mode == MODE_WAIT) begin
          tape_mem[head] = c.input_byte;
          pc++;
        end
        bf_run(st, ob);
      end
    endcase
    r.status = st;
    r.out_byte = ob;
    r.program_length = 13'(prog_len);
    return r;
  endfunction

  // Offer one word. If the word is held back, start drops for the gap first. If it is
  // not, start simply stays high, so start is never lowered and raised again in the
  // same time step. The answer is predicted at the edge where the word is accepted.
  task automatic send_word(input cmd_t w, output result_t due);
    int unsigned gap;
    gap = pace_free ? 0 : $urandom_range(0, GAP_MAX);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    cmd <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    due = bf_answer(w);
    answers_due.insert(answers_due.size(), due);
    words_sent++;
  endtask

  // Build a command word with the given opcode and input byte. The fields that this
  // opcode does not use are filled with random values.
  task automatic issue(input logic [1:0] op, input logic [7:0] ibyte, output result_t r);
    cmd_t w;
    w.opcode = op;
    w.object_flags = 8'($urandom);
    w.sound_flags = 4'($urandom);
    w.input_byte = ibyte;
    send_word(w, r);
  endtask

  // Input bytes lean towards the two extremes.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 5))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // One token bit carried by a real note. A skipped note may be sent ahead of it.
  task automatic load_bit(input logic b);
    cmd_t    w;
    result_t r;
    w.opcode = OPC_LOAD;
    w.input_byte = 8'($urandom);
    if ($urandom_range(0, 99) < skip_pct) begin
      w.object_flags = 8'($urandom);
      while ((w.object_flags & SKIP_MASK) == 0) w.object_flags = 8'($urandom);
      w.sound_flags = 4'($urandom);
      send_word(w, r);
    end
    w.object_flags = 8'($urandom) & ~SKIP_MASK;
    w.sound_flags = 4'($urandom);
    if (b) begin
      while ((w.sound_flags & ONE_MASK) == 0) w.sound_flags = 4'($urandom);
    end else begin
      w.sound_flags = w.sound_flags & ~ONE_MASK;
    end
    send_word(w, r);
  endtask

  // An instruction takes three notes. The most significant bit comes first.
  task automatic load_ins(input logic [2:0] code);
    for (int k = 2; k >= 0; k--) load_bit(code[k]);
  endtask

  task automatic load_text(input string s);
    logic [2:0] code;
    for (int i = 0; i < s.len(); i++) begin
      case (s[i])
        ">":     code = INS_RIGHT;
        "<":     code = INS_LEFT;
        "+":     code = INS_INC;
        "-":     code = INS_DEC;
        ".":     code = INS_OUT;
        ",":     code = INS_IN;
        "[":     code = INS_OPEN;
        default: code = INS_CLOSE;
      endcase
      load_ins(code);
    end
  endtask

  // Keep continuing while the run is only paused. Paused means after an output, after an
  // input request, or at the end of a time slice. When noisy is set, the paused run may
  // have harmless instructions appended to it, or be cleared away.
  task automatic run_out(input result_t first, input int unsigned cap, input bit noisy);
    result_t     r;
    result_t     dummy;
    int unsigned n;
    r = first;
    n = 0;
    programs_run++;
    while ((r.status == ST_OUTPUT || r.status == ST_NEED_INPUT || r.status == ST_ACK)
           && n < cap) begin
      if (noisy && token_bits == 0 && $urandom_range(0, 15) == 0) begin
        load_ins(3'($urandom_range(INS_RIGHT, INS_OUT)));
      end else if (noisy && $urandom_range(0, 30) == 0) begin
        // A clear kills the paused run, so the continue that follows is refused.
        issue(OPC_CLEAR, pick_byte(), dummy);
        issue(OPC_CONT, pick_byte(), dummy);
        break;
      end
      issue(OPC_CONT, pick_byte(), r);
      n++;
    end
  endtask

  // Note decoding, skipped notes, partial tokens, a continue with nothing paused, and a
  // start on an empty program.
  task automatic test_note_decoding();
    result_t r;
    issue(OPC_CONT, 8'hFF, r);
    issue(OPC_START, 8'h00, r);
    send_word('{OPC_LOAD, 8'hFF, 4'hF, 8'h00}, r);
    send_word('{OPC_LOAD, 8'h02, 4'hF, 8'hFF}, r);
    send_word('{OPC_LOAD, 8'h08, 4'h0, 8'h00}, r);
    // Clap and whistle each give a one. The other two sound bits give nothing.
    send_word('{OPC_LOAD, 8'h00, 4'hF, 8'h00}, r);
    send_word('{OPC_LOAD, 8'hF5, 4'h5, 8'hFF}, r);
    send_word('{OPC_LOAD, 8'h00, 4'h2, 8'h00}, r);
    send_word('{OPC_LOAD, 8'hF5, 4'h8, 8'hFF}, r);
    send_word('{OPC_LOAD, 8'h00, 4'h0, 8'h00}, r);
    send_word('{OPC_LOAD, 8'hF5, 4'hA, 8'hFF}, r);
    // A half-built token is thrown away by a clear.
    send_word('{OPC_LOAD, 8'h00, 4'hF, 8'h00}, r);
    issue(OPC_CLEAR, 8'h00, r);
    send_word('{OPC_LOAD, 8'h00, 4'h0, 8'h00}, r);
    send_word('{OPC_LOAD, 8'h00, 4'h5, 8'h00}, r);
    send_word('{OPC_LOAD, 8'hF5, 4'h0, 8'h00}, r);
    issue(OPC_CLEAR, 8'h00, r);
  endtask

  // Output and input with extreme bytes, cell wrap in both directions, pointer wrap
  // through cell zero, a load into a paused run, and a clear during an input request.
  task automatic test_byte_io();
    result_t r;
    load_text("-.+.,.,.<+.>.");
    issue(OPC_START, 8'h00, r);
    load_text(",");
    issue(OPC_CONT, 8'hFF, r);
    issue(OPC_CONT, 8'h00, r);
    issue(OPC_CONT, 8'h00, r);
    issue(OPC_CONT, 8'h00, r);
    issue(OPC_CONT, 8'hFF, r);
    issue(OPC_CONT, 8'h00, r);
    issue(OPC_CONT, 8'h00, r);
    issue(OPC_CONT, 8'h00, r);
    issue(OPC_CLEAR, 8'h00, r);
    issue(OPC_CONT, 8'h00, r);
  endtask

  // Unmatched brackets in both directions, and nested loops behind a leading close
  // bracket that is not taken.
  task automatic test_brackets();
    result_t r;
    load_text("+]");
    issue(OPC_START, 8'h00, r);
    issue(OPC_CONT, 8'h00, r);
    issue(OPC_CLEAR, 8'h00, r);
    load_text("[");
    issue(OPC_START, 8'h00, r);
    issue(OPC_CLEAR, 8'h00, r);
    load_text("]++[>++[>+<-]<-]>>.[");
    issue(OPC_START, 8'h00, r);
    run_out(r, 4, 1'b0);
    issue(OPC_CLEAR, 8'h00, r);
  endtask

  // A run that is longer than one time slice but shorter than two.
  task automatic test_time_slice();
    result_t r;
    load_text("+++++++++[>++++++++++++++++<-]>[>-[-]<-].");
    issue(OPC_START, 8'h00, r);
    run_out(r, 6, 1'b0);
    issue(OPC_CLEAR, 8'h00, r);
  endtask

  // Random programs that always terminate. Each loop body sits one cell to the right of
  // its counter and counts that counter down. Now and then a single stray bracket is
  // placed between segments to provoke a bracket error.
  task automatic test_random_programs();
    logic [2:0]  codes[$];
    int unsigned cuts[$];
    result_t     r;
    int unsigned first_word;
    int unsigned segs;
    int unsigned body;
    first_word = words_sent;
    while (words_sent - first_word < RANDOM_WORDS) begin
      pace_free = ($urandom_range(0, 3) == 0);
      skip_pct = $urandom_range(0, 12);
      codes.delete();
      cuts.delete();
      segs = $urandom_range(6, 18);
      repeat (segs) begin
        cuts.insert(cuts.size(), codes.size());
        case ($urandom_range(0, 9))
          0, 1: codes.insert(codes.size(), INS_INC);
          2:    codes.insert(codes.size(), INS_DEC);
          3:    codes.insert(codes.size(), INS_RIGHT);
          4:    codes.insert(codes.size(), INS_LEFT);
          5:    codes.insert(codes.size(), INS_OUT);
          6:    codes.insert(codes.size(), INS_IN);
          default: begin
            codes.insert(codes.size(), INS_OPEN);
            codes.insert(codes.size(), INS_RIGHT);
            body = $urandom_range(0, 3);
            repeat (body) begin
              case ($urandom_range(0, 4))
                0: codes.insert(codes.size(), INS_INC);
                1: codes.insert(codes.size(), INS_DEC);
                2: codes.insert(codes.size(), INS_OUT);
                3: codes.insert(codes.size(), INS_IN);
                default: begin
                  codes.insert(codes.size(), INS_OPEN);
                  codes.insert(codes.size(), INS_DEC);
                  codes.insert(codes.size(), INS_CLOSE);
                end
              endcase
            end
            codes.insert(codes.size(), INS_LEFT);
            codes.insert(codes.size(), INS_DEC);
            codes.insert(codes.size(), INS_CLOSE);
          end
        endcase
      end
      cuts.insert(cuts.size(), codes.size());
      if ($urandom_range(0, 5) == 0) begin
        codes.insert(cuts[$urandom_range(0, cuts.size() - 1)],
                     $urandom_range(0, 1) ? INS_OPEN : INS_CLOSE);
      end

      issue(OPC_CLEAR, pick_byte(), r);
      if ($urandom_range(0, 3) == 0) issue(OPC_CONT, pick_byte(), r);
      if ($urandom_range(0, 9) == 0) issue(OPC_START, pick_byte(), r);
      foreach (codes[i]) load_ins(codes[i]);
      issue(OPC_START, pick_byte(), r);
      run_out(r, 40, 1'b1);
      if ($urandom_range(0, 2) == 0) issue(OPC_CONT, pick_byte(), r);
    end
    pace_free = 1'b0;
  endtask

  // Each result word is valid for one cycle only. It is taken at the edge that ends
  // that cycle and compared with the oldest answer still owed.
  always @(posedge clk) begin
    if (!rst && done) begin
      results_seen++;
      if (answers_due.size() == 0) begin
        $display("%0t: unexpected result word status %0d out_byte %0d program_length %0d",
                 $time, result.status, result.out_byte, result.program_length);
        errors++;
      end else begin
        want_word = answers_due.pop_front();
        if (want_word.status == ST_OUTPUT) bytes_out++;
        if (want_word.status == ST_NEED_INPUT) input_waits++;
        if (result.status !== want_word.status) begin
          $display("%0t: status expected %0d actual %0d",
                   $time, want_word.status, result.status);
          errors++;
        end
        if (result.out_byte !== want_word.out_byte) begin
          $display("%0t: out_byte expected %0d actual %0d",
                   $time, want_word.out_byte, result.out_byte);
          errors++;
        end
        if (result.program_length !== want_word.program_length) begin
          $display("%0t: program_length expected %0d actual %0d",
                   $time, want_word.program_length, result.program_length);
          errors++;
        end
      end
    end
  end

  // Watchdog. It catches a block that hangs or never answers.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("%0t: cycle limit reached with %0d results outstanding",
               $time, answers_due.size());
      $display("tb_note_coded_brainfuck_machine: done, errors");
      $finish;
    end
  end

  initial begin
    foreach (tape_mem[k]) tape_mem[k] = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_note_decoding();
    test_byte_io();
    test_brackets();
    test_time_slice();
    test_random_programs();

    // The last send returned at its acceptance edge, so start can drop here.
    start <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d command words over %0d program runs and checked %0d result words.",
             words_sent, programs_run, results_seen);
    $display("Results included %0d output bytes and %0d input requests.",
             bytes_out, input_waits);
    if (errors == 0) begin
      $display("tb_note_coded_brainfuck_machine: done, clean");
    end else begin
      $display("tb_note_coded_brainfuck_machine: done, errors");
    end
    $finish;
  end

endmodule
